// ===== hw/rtl/crockb32_pkg.sv =====
// Shared types and constants for the Crockford base32 code decoder.
package crockb32_pkg;

    localparam int CHAR_W     = 8;
    localparam int SYM_W      = 5;
    localparam int ACC_W      = 12;
    localparam int PEND_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [PEND_W-1:0] BITS_PER_SYM  = PEND_W'(SYM_W);
    localparam logic [PEND_W-1:0] BITS_PER_BYTE = PEND_W'(BYTE_W);

    typedef enum logic [1:0] {
        CLS_SYM = 2'd0,
        CLS_SEP = 2'd1,
        CLS_BAD = 2'd2
    } char_class_t;

    typedef struct packed {
        char_class_t        cls;
        logic [SYM_W-1:0]   value;
    } sym_info_t;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_VERDICT = 1'b1
    } result_kind_t;

endpackage

// ===== hw/rtl/crockb32_sym_dec.sv =====
// Character classifier and symbol lookup for the Crockford base32 alphabet.
module crockb32_sym_dec (
    input  logic [crockb32_pkg::CHAR_W-1:0] char_code,
    output crockb32_pkg::sym_info_t         sym_info
);

    logic [crockb32_pkg::CHAR_W-1:0] upper;

    always_comb begin
        if (char_code >= "a" && char_code <= "z") begin
            upper = char_code - 8'd32;
        end else begin
            upper = char_code;
        end
    end

    always_comb begin
        sym_info.cls   = crockb32_pkg::CLS_SYM;
        sym_info.value = '0;
        unique case (upper) inside
            ["0":"9"]: sym_info.value = crockb32_pkg::SYM_W'(upper - "0");
            ["A":"H"]: sym_info.value = crockb32_pkg::SYM_W'(upper - "A" + 8'd10);
            "I", "L":  sym_info.value = 5'd1;
            "O":       sym_info.value = 5'd0;
            "J":       sym_info.value = 5'd18;
            "K":       sym_info.value = 5'd19;
            "M":       sym_info.value = 5'd20;
            "N":       sym_info.value = 5'd21;
            "P":       sym_info.value = 5'd22;
            "Q":       sym_info.value = 5'd23;
            "R":       sym_info.value = 5'd24;
            "S":       sym_info.value = 5'd25;
            "T":       sym_info.value = 5'd26;
            "V":       sym_info.value = 5'd27;
            "W":       sym_info.value = 5'd28;
            "X":       sym_info.value = 5'd29;
            "Y":       sym_info.value = 5'd30;
            "Z":       sym_info.value = 5'd31;
            "-", " ", "_": sym_info.cls = crockb32_pkg::CLS_SEP;
            default:   sym_info.cls = crockb32_pkg::CLS_BAD;
        endcase
    end

endmodule

// ===== hw/rtl/crockford_base32_code_decoder_core.sv =====
// Top level of the Crockford base32 pairing-code decoder.
// The input channel carries one request per character: s_tdata holds the ASCII
// code and s_tuser marks the end of a code, which carries no character.
// Separators are dropped, and any other character outside the alphabet marks
// the code as failed and silences the rest of it.
// Each completed byte, up to SECRET_BYTES per code, comes out on the result channel
// with m_tuser low, its value in m_tdata[7:0] and its position in m_tdata[11:8].
// The end marker always yields one verdict with m_tuser high and the pass flag
// in m_tdata[12], and then the decoder starts over on a fresh code.
// One character is taken every cycle while s_tready is high; a result appears in the
// cycle after its request, held in the single output register.
// When the receiver stalls while the output register holds a result,
// s_tready stays low, so no character is taken until the register drains.
// Reset clears all decoding state and empties the output register.
module crockford_base32_code_decoder_core #(
    parameter int SECRET_BYTES     = 15,
    parameter int EXPECTED_SYMBOLS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [crockb32_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] char_code
    input  logic                                 s_tuser,  // [0] end_of_code

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [crockb32_pkg::M_TDATA_W-1:0]   m_tdata,  // [7:0] data_byte,
                                                           // [11:8] byte_index,
                                                           // [12] code_valid
    output logic                                 m_tuser   // [0] result_kind
);

    localparam int SCNT_W = $clog2(EXPECTED_SYMBOLS + 2);
    localparam int BCNT_W = $clog2(SECRET_BYTES + 1);
    localparam logic [SCNT_W-1:0] SYM_SAT    = SCNT_W'(EXPECTED_SYMBOLS + 1);
    localparam logic [SCNT_W-1:0] SYM_TARGET = SCNT_W'(EXPECTED_SYMBOLS);
    localparam logic [BCNT_W-1:0] BYTE_LIMIT = BCNT_W'(SECRET_BYTES);

    logic [crockb32_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [crockb32_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [SCNT_W-1:0]               scnt_reg, scnt_next;
    logic [BCNT_W-1:0]               bcnt_reg, bcnt_next;
    logic                            bad_reg, bad_next;

    logic                            out_valid_reg, out_valid_next;
    crockb32_pkg::result_kind_t      out_kind_reg, out_kind_next;
    logic [crockb32_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [crockb32_pkg::IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic                            out_ok_reg, out_ok_next;

    crockb32_pkg::sym_info_t         sym_info;
    logic                            accept;
    logic                            has_result;
    logic [crockb32_pkg::ACC_W-1:0]  acc_shift;
    logic [crockb32_pkg::PEND_W-1:0] pend_sum;
    logic [crockb32_pkg::PEND_W-1:0] pend_left;

    crockb32_sym_dec u_sym_dec (
        .char_code (s_tdata[crockb32_pkg::CHAR_W-1:0]),
        .sym_info  (sym_info)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign acc_shift = {acc_reg[crockb32_pkg::ACC_W-crockb32_pkg::SYM_W-1:0], sym_info.value};
    assign pend_sum  = pend_reg + crockb32_pkg::BITS_PER_SYM;
    assign pend_left = pend_sum - crockb32_pkg::BITS_PER_BYTE;

    always_comb begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        scnt_next     = scnt_reg;
        bcnt_next     = bcnt_reg;
        bad_next      = bad_reg;
        has_result    = 1'b0;
        out_kind_next = crockb32_pkg::KIND_BYTE;
        out_byte_next = '0;
        out_idx_next  = '0;
        out_ok_next   = 1'b0;

        if (s_tuser) begin
            has_result    = 1'b1;
            out_kind_next = crockb32_pkg::KIND_VERDICT;
            out_ok_next   = !bad_reg && (scnt_reg == SYM_TARGET) && (bcnt_reg == BYTE_LIMIT);
            acc_next      = '0;
            pend_next     = '0;
            scnt_next     = '0;
            bcnt_next     = '0;
            bad_next      = 1'b0;
        end else if (!bad_reg) begin
            case (sym_info.cls)
                crockb32_pkg::CLS_SYM: begin
                    acc_next = acc_shift;
                    if (scnt_reg < SYM_SAT) begin
                        scnt_next = scnt_reg + 1'b1;
                    end
                    if (pend_sum >= crockb32_pkg::BITS_PER_BYTE) begin
                        pend_next = pend_left;
                        if (bcnt_reg < BYTE_LIMIT) begin
                            has_result    = 1'b1;
                            out_byte_next = crockb32_pkg::BYTE_W'(acc_shift >> pend_left);
                            out_idx_next  = crockb32_pkg::IDX_W'(bcnt_reg);
                            bcnt_next     = bcnt_reg + 1'b1;
                        end
                    end else begin
                        pend_next = pend_sum;
                    end
                end
                crockb32_pkg::CLS_BAD: bad_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = has_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            scnt_reg      <= '0;
            bcnt_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                scnt_reg <= scnt_next;
                bcnt_reg <= bcnt_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has_result) begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_idx_reg  <= out_idx_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_ok_reg, out_idx_reg, out_byte_reg};

    // Fewer than eight bits are ever left waiting between characters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg < crockb32_pkg::BITS_PER_BYTE)
        else $error("pending bit count reached a full byte");

    // The symbol and byte counts never pass their limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scnt_reg <= SYM_SAT) && (bcnt_reg <= BYTE_LIMIT))
        else $error("symbol or byte count beyond its limit");

    // An end marker leaves the decoder cleared for the next code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> (scnt_reg == '0) && (bcnt_reg == '0) && !bad_reg
                                && (pend_reg == '0))
        else $error("state not cleared after end of code");

    // An end marker always leaves its verdict in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> m_tvalid && (m_tuser == crockb32_pkg::KIND_VERDICT))
        else $error("verdict missing after end of code");

endmodule
